// ----- rtl/core/uartf_pkg.sv -----
// ----------------------------------------------------------------------------
// uartf_pkg
// Shared types and constants for the 8N1 bit framer / deframer with FIFOs.
// ----------------------------------------------------------------------------
package uartf_pkg;

    // Operation selector carried on s_tuser
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_TX_BIT = 2'd2,
        OP_RX_BIT = 2'd3
    } opcode_t;

    // Frame geometry
    localparam int unsigned FRAME_BITS = 10;
    localparam int unsigned DATA_BITS  = 8;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PENDING_W = 6;
    localparam int unsigned ERRCNT_W  = 16;
    localparam int unsigned SHIFT_W   = FRAME_BITS;
    localparam int unsigned BITCNT_W  = 4;

    // Stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 1;

    // Bits left in a frame after its start bit has gone out
    localparam logic [BITCNT_W-1:0] TX_LEFT_AFTER_START = BITCNT_W'(FRAME_BITS - 1);
    localparam logic [BITCNT_W-1:0] RX_BITS_PER_BYTE    = BITCNT_W'(DATA_BITS);

endpackage

// ----- rtl/core/uart_8n1_bit_framer_with_fifos_unit.sv -----
// ----------------------------------------------------------------------------
// uart_8n1_bit_framer_with_fifos_unit
// 8N1 serial framer and deframer, each side with a ring FIFO of
// QUEUE_DEPTH-1 bytes; one operation per beat.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+-----------
//  s_      | in  | data_byte[7:0], rx_bit[8], zero pad         | opcode[1:0]
//  m_      | out | read_data[7:0], tx_bit[8], tx_pending[14:9], | accepted[0]
//          |     | framing_error_count[30:15], zero pad        |
//
//  One beat per cycle sustained while m_tready is high; a beat is taken into
//  the input register, and its result is then loaded into the result register.
//  FIFO head bytes are prefetched from the store's registered read port, with
//  a write bypass, so push/pop/emit never wait on the memory.
//  Reset (aresetn low, synchronous) clears pointers, framer state and the
//  error counter; FIFO stores are not cleared.
//  A stall on m_tready holds the result register and backs up into s_tready.
// ----------------------------------------------------------------------------
module uart_8n1_bit_framer_with_fifos_unit #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // data_byte[7:0], rx_bit[8], zero pad
    input  logic [uartf_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [uartf_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // read_data[7:0], tx_bit[8], tx_pending[14:9], framing_error_count[30:15]
    output logic [uartf_pkg::M_TDATA_W-1:0] m_tdata,
    // accepted[0]
    output logic [uartf_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import uartf_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = (PW > PENDING_W) ? PW : PENDING_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // Input register
    logic                in_valid_reg;
    opcode_t             in_op_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_bit_reg;

    // Result register
    logic                out_valid_reg;
    logic                out_acc_reg;
    logic [BYTE_W-1:0]   out_rd_reg;
    logic                out_txb_reg;
    logic [PENDING_W-1:0] out_pend_reg;
    logic [ERRCNT_W-1:0] out_err_reg;

    // Transmit side state
    logic [PW-1:0]       tx_rd_reg, tx_rd_next;
    logic [PW-1:0]       tx_wr_reg, tx_wr_next;
    logic [PW-1:0]       tx_count_reg, tx_count_next;
    logic [SHIFT_W-1:0]  tx_shift_reg, tx_shift_next;
    logic [BITCNT_W-1:0] tx_left_reg, tx_left_next;
    logic [BYTE_W-1:0]   tx_head_reg;
    logic                tx_we;

    // Receive side state
    logic [PW-1:0]       rx_rd_reg, rx_rd_next;
    logic [PW-1:0]       rx_wr_reg, rx_wr_next;
    logic                rx_frame_reg, rx_frame_next;
    logic [BYTE_W-1:0]   rx_shift_reg, rx_shift_next;
    logic [BITCNT_W-1:0] rx_taken_reg, rx_taken_next;
    logic [BYTE_W-1:0]   rx_head_reg;
    logic                rx_we;

    logic [ERRCNT_W-1:0] err_reg, err_next;

    // Result of the beat being processed
    logic                acc_c;
    logic [BYTE_W-1:0]   rd_c;
    logic                txb_c;
    logic [CW-1:0]       pend_wide;

    logic out_ready;
    logic proc;

    logic [BYTE_W-1:0] tx_mem [QUEUE_DEPTH];
    logic [BYTE_W-1:0] rx_mem [QUEUE_DEPTH];

    // Handshake chain
    assign out_ready = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_op_reg   <= opcode_t'(s_tuser[1:0]);
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_bit_reg  <= s_tdata[BYTE_W];
        end
    end

    // Operation logic
    always_comb begin
        tx_rd_next    = tx_rd_reg;
        tx_wr_next    = tx_wr_reg;
        tx_count_next = tx_count_reg;
        tx_shift_next = tx_shift_reg;
        tx_left_next  = tx_left_reg;
        tx_we         = 1'b0;
        rx_rd_next    = rx_rd_reg;
        rx_wr_next    = rx_wr_reg;
        rx_frame_next = rx_frame_reg;
        rx_shift_next = rx_shift_reg;
        rx_taken_next = rx_taken_reg;
        rx_we         = 1'b0;
        err_next      = err_reg;
        acc_c         = 1'b0;
        rd_c          = '0;
        txb_c         = 1'b1;
        if (proc) begin
            case (in_op_reg)
                OP_PUSH: begin
                    if (advance(tx_wr_reg) != tx_rd_reg) begin
                        tx_we         = 1'b1;
                        tx_wr_next    = advance(tx_wr_reg);
                        tx_count_next = tx_count_reg + 1'b1;
                        acc_c         = 1'b1;
                    end
                end
                OP_POP: begin
                    if (rx_rd_reg != rx_wr_reg) begin
                        rd_c       = rx_head_reg;
                        rx_rd_next = advance(rx_rd_reg);
                        acc_c      = 1'b1;
                    end
                end
                OP_TX_BIT: begin
                    if (tx_left_reg == '0) begin
                        // start a new frame: the start bit goes out now
                        if (tx_rd_reg != tx_wr_reg) begin
                            txb_c         = 1'b0;
                            tx_shift_next = {1'b0, 1'b1, tx_head_reg};
                            tx_left_next  = TX_LEFT_AFTER_START;
                            tx_rd_next    = advance(tx_rd_reg);
                            tx_count_next = tx_count_reg - 1'b1;
                        end
                    end else begin
                        txb_c         = tx_shift_reg[0];
                        tx_shift_next = tx_shift_reg >> 1;
                        tx_left_next  = tx_left_reg - 1'b1;
                    end
                end
                OP_RX_BIT: begin
                    if (!rx_frame_reg) begin
                        if (!in_bit_reg) begin
                            rx_frame_next = 1'b1;
                            rx_shift_next = '0;
                            rx_taken_next = '0;
                        end
                    end else if (rx_taken_reg < RX_BITS_PER_BYTE) begin
                        rx_shift_next = rx_shift_reg
                                      | (BYTE_W'(in_bit_reg) << rx_taken_reg[2:0]);
                        rx_taken_next = rx_taken_reg + 1'b1;
                    end else begin
                        // stop bit
                        if (in_bit_reg) begin
                            if (advance(rx_wr_reg) != rx_rd_reg) begin
                                rx_we      = 1'b1;
                                rx_wr_next = advance(rx_wr_reg);
                            end
                        end else begin
                            err_next = err_reg + 1'b1;
                        end
                        rx_frame_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign pend_wide = CW'(tx_count_next);

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_rd_reg    <= '0;
            tx_wr_reg    <= '0;
            tx_count_reg <= '0;
            tx_shift_reg <= '0;
            tx_left_reg  <= '0;
            rx_rd_reg    <= '0;
            rx_wr_reg    <= '0;
            rx_frame_reg <= 1'b0;
            rx_shift_reg <= '0;
            rx_taken_reg <= '0;
            err_reg      <= '0;
        end else begin
            tx_rd_reg    <= tx_rd_next;
            tx_wr_reg    <= tx_wr_next;
            tx_count_reg <= tx_count_next;
            tx_shift_reg <= tx_shift_next;
            tx_left_reg  <= tx_left_next;
            rx_rd_reg    <= rx_rd_next;
            rx_wr_reg    <= rx_wr_next;
            rx_frame_reg <= rx_frame_next;
            rx_shift_reg <= rx_shift_next;
            rx_taken_reg <= rx_taken_next;
            err_reg      <= err_next;
        end
    end

    // Transmit store: head byte prefetched at the next read pointer
    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_wr_reg] <= in_byte_reg;
        end
        if (tx_we && (tx_wr_reg == tx_rd_next)) begin
            tx_head_reg <= in_byte_reg;
        end else begin
            tx_head_reg <= tx_mem[tx_rd_next];
        end
    end

    // Receive store: same prefetch scheme
    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_wr_reg] <= rx_shift_reg;
        end
        if (rx_we && (rx_wr_reg == rx_rd_next)) begin
            rx_head_reg <= rx_shift_reg;
        end else begin
            rx_head_reg <= rx_mem[rx_rd_next];
        end
    end

    // Result register; the error count is the one seen by this beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc) begin
            out_acc_reg  <= acc_c;
            out_rd_reg   <= rd_c;
            out_txb_reg  <= txb_c;
            out_pend_reg <= pend_wide[PENDING_W-1:0];
            out_err_reg  <= err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_acc_reg;
    assign m_tdata  = {1'b0, out_err_reg, out_pend_reg, out_txb_reg, out_rd_reg};

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_count_reg <= PTR_LAST)
        else $error("tx count exceeds FIFO capacity");

    a_stop_bit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (tx_left_reg == BITCNT_W'(1)) |-> (tx_shift_reg == SHIFT_W'(1)))
        else $error("last frame bit is not a lone stop bit");

    a_tx_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_left_reg <= TX_LEFT_AFTER_START)
        else $error("tx bit counter out of range");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && (in_op_reg == OP_POP) && (rx_rd_reg == rx_wr_reg)) |=> !out_acc_reg)
        else $error("pop accepted from empty receive FIFO");

endmodule
